FILE: rtl/nerl_pkg.sv
// Shared types and constants for the narrowest enclosing range lookup.
// Holds the command and status codes, the chain control struct and a width helper.
package nerl_pkg;

  localparam int MaxDefsDefault  = 256;
  localparam int LineBitsDefault = 20;
  localparam int ColBitsDefault  = 16;

  localparam int SpanLineWeight = 1000000;
  localparam int WeightBits     = 20;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REVERSED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic valid;
    logic load;
    logic query;
  } tok_ctl_t;

  function automatic int span_bits(input int line_bits, input int col_bits);
    int w;
    w = line_bits + WeightBits;
    if (col_bits > w) begin
      w = col_bits;
    end
    return w + 1;
  endfunction

endpackage

FILE: rtl/nerl_entry.sv
// Entry stage of the lookup chain: decodes the command, keeps the definition
// count and forms the span of a loaded range. Depends on nerl_pkg.
module nerl_entry #(
  parameter int MAX_DEFS  = nerl_pkg::MaxDefsDefault,
  parameter int LINE_BITS = nerl_pkg::LineBitsDefault,
  parameter int COL_BITS  = nerl_pkg::ColBitsDefault,
  localparam int CNT_W    = $clog2(MAX_DEFS + 1),
  localparam int POS_W    = LINE_BITS + COL_BITS,
  localparam int SPAN_W   = nerl_pkg::span_bits(LINE_BITS, COL_BITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  input  logic [LINE_BITS-1:0] start_line_i,
  input  logic [COL_BITS-1:0]  start_col_i,
  input  logic [LINE_BITS-1:0] end_line_i,
  input  logic [COL_BITS-1:0]  end_col_i,
  output nerl_pkg::tok_ctl_t ctl_o,
  output logic [POS_W-1:0]   sp_o,
  output logic [POS_W-1:0]   ep_o,
  output logic [SPAN_W-1:0]  span_o,
  output logic [CNT_W-1:0]   cnt_o,
  output logic [1:0]         status_o
);
  import nerl_pkg::*;

  logic [POS_W-1:0]     sp;
  logic [POS_W-1:0]     ep;
  logic                 reversed;
  logic                 full;
  tok_ctl_t             ctl_d, ctl_q;
  status_e              status_d, status_q;
  logic [CNT_W-1:0]     cnt_d, cnt_q;
  logic [CNT_W-1:0]     tok_cnt_q;
  logic [POS_W-1:0]     sp_q, ep_q;
  logic [LINE_BITS-1:0] line_diff;

  assign sp       = {start_line_i, start_col_i};
  assign ep       = {end_line_i, end_col_i};
  assign reversed = ep < sp;
  assign full     = cnt_q == CNT_W'(MAX_DEFS);

  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = in_valid_i;
    status_d    = ST_OK;
    cnt_d       = cnt_q;
    unique case (cmd_e'(cmd_i))
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      CMD_LOAD: begin
        if (reversed) begin
          status_d = ST_REVERSED;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl_d.load = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        if (reversed) begin
          status_d = ST_REVERSED;
        end else begin
          ctl_d.query = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      cnt_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
      if (in_valid_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sp_q      <= sp;
      ep_q      <= ep;
      tok_cnt_q <= cnt_q;
      status_q  <= status_d;
    end
  end

  assign line_diff = ep_q[POS_W-1 -: LINE_BITS] - sp_q[POS_W-1 -: LINE_BITS];
  assign span_o    = SPAN_W'(line_diff) * SPAN_W'(SpanLineWeight)
                   + SPAN_W'(ep_q[COL_BITS-1:0]) - SPAN_W'(sp_q[COL_BITS-1:0]);

  assign ctl_o    = ctl_q;
  assign sp_o     = sp_q;
  assign ep_o     = ep_q;
  assign cnt_o    = tok_cnt_q;
  assign status_o = status_q;

endmodule

FILE: rtl/nerl_cell.sv
// One cell of the lookup chain: holds one stored definition, writes it on a
// matching load beat and refines the best container of a passing query. Uses nerl_pkg.
module nerl_cell #(
  parameter int MAX_DEFS  = nerl_pkg::MaxDefsDefault,
  parameter int LINE_BITS = nerl_pkg::LineBitsDefault,
  parameter int COL_BITS  = nerl_pkg::ColBitsDefault,
  parameter int IDX       = 0,
  localparam int CNT_W    = $clog2(MAX_DEFS + 1),
  localparam int POS_W    = LINE_BITS + COL_BITS,
  localparam int SPAN_W   = nerl_pkg::span_bits(LINE_BITS, COL_BITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  nerl_pkg::tok_ctl_t ctl_i,
  input  logic [POS_W-1:0]   sp_i,
  input  logic [POS_W-1:0]   ep_i,
  input  logic [SPAN_W-1:0]  span_i,
  input  logic [CNT_W-1:0]   cnt_i,
  input  logic [CNT_W-1:0]   best_i,
  input  logic [SPAN_W-1:0]  best_span_i,
  input  logic [1:0]         status_i,
  output nerl_pkg::tok_ctl_t ctl_o,
  output logic [POS_W-1:0]   sp_o,
  output logic [POS_W-1:0]   ep_o,
  output logic [SPAN_W-1:0]  span_o,
  output logic [CNT_W-1:0]   cnt_o,
  output logic [CNT_W-1:0]   best_o,
  output logic [SPAN_W-1:0]  best_span_o,
  output logic [1:0]         status_o
);
  import nerl_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MyNum = CNT_W'(IDX + 1);

  tok_ctl_t          ctl_q;
  logic [POS_W-1:0]  def_start_q, def_end_q;
  logic [SPAN_W-1:0] def_span_q;
  logic [POS_W-1:0]  sp_q, ep_q;
  logic [SPAN_W-1:0] span_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  best_d, best_q;
  logic [SPAN_W-1:0] best_span_d, best_span_q;
  logic [1:0]        status_q;
  logic              wr_en;
  logic              hit;

  assign wr_en = adv_i && ctl_i.valid && ctl_i.load && (cnt_i == MyIdx);
  assign hit   = ctl_i.query && (MyIdx < cnt_i)
              && (def_start_q <= sp_i) && (def_end_q >= ep_i)
              && ((best_i == '0) || (def_span_q < best_span_i));

  always_comb begin
    best_d      = best_i;
    best_span_d = best_span_i;
    if (hit) begin
      best_d      = MyNum;
      best_span_d = def_span_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      def_start_q <= sp_i;
      def_end_q   <= ep_i;
      def_span_q  <= span_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sp_q        <= sp_i;
      ep_q        <= ep_i;
      span_q      <= span_i;
      cnt_q       <= cnt_i;
      best_q      <= best_d;
      best_span_q <= best_span_d;
      status_q    <= status_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign sp_o        = sp_q;
  assign ep_o        = ep_q;
  assign span_o      = span_q;
  assign cnt_o       = cnt_q;
  assign best_o      = best_q;
  assign best_span_o = best_span_q;
  assign status_o    = status_q;

endmodule

FILE: rtl/narrowest_enclosing_range_lookup.sv
// Top level of the narrowest enclosing range lookup: entry stage and a row of
// definition cells. Depends on nerl_pkg, nerl_entry and nerl_cell.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with cmd_i and the range fields.
//   A beat is taken at a rising edge with in_valid_i high and in_stall_o low.
//   Commands: clear empties the table, load appends one range, query returns
//   the 1-based index of the narrowest stored range that encloses the query.
//   Output channel: out_valid_o / out_stall_i with status_o and container_o,
//   one result beat per input beat, in input order.
//   Path: each input beat passes the entry register and then one register
//   per definition cell in the row before it leaves as a result beat.
//   Throughput: one beat per cycle while the row is not held by a stall;
//   beats travel the row back to back, so a query sees exactly the loads and clears that came before it.
//   Stall: when a result waits and out_stall_i is high the whole row holds
//   and in_stall_o rises in the same cycle; nothing is dropped.
//   Reset: clears the definition count and all beat valids; stored ranges
//   need no clearing, since only entries below the count are consulted.
module narrowest_enclosing_range_lookup #(
  parameter int MAX_DEFS  = nerl_pkg::MaxDefsDefault,
  parameter int LINE_BITS = nerl_pkg::LineBitsDefault,
  parameter int COL_BITS  = nerl_pkg::ColBitsDefault,
  localparam int CNT_W    = $clog2(MAX_DEFS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [LINE_BITS-1:0] start_line_i,
  input  logic [COL_BITS-1:0]  start_col_i,
  input  logic [LINE_BITS-1:0] end_line_i,
  input  logic [COL_BITS-1:0]  end_col_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [CNT_W-1:0]     container_o
);
  import nerl_pkg::*;

  localparam int POS_W  = LINE_BITS + COL_BITS;
  localparam int SPAN_W = span_bits(LINE_BITS, COL_BITS);

  logic              adv;
  tok_ctl_t          ctl_s       [MAX_DEFS+1];
  logic [POS_W-1:0]  sp_s        [MAX_DEFS+1];
  logic [POS_W-1:0]  ep_s        [MAX_DEFS+1];
  logic [SPAN_W-1:0] span_s      [MAX_DEFS+1];
  logic [CNT_W-1:0]  cnt_s       [MAX_DEFS+1];
  logic [CNT_W-1:0]  best_s      [MAX_DEFS+1];
  logic [SPAN_W-1:0] best_span_s [MAX_DEFS+1];
  logic [1:0]        status_s    [MAX_DEFS+1];

  assign adv        = !ctl_s[MAX_DEFS].valid || !out_stall_i;
  assign in_stall_o = !adv;

  nerl_entry #(
    .MAX_DEFS  (MAX_DEFS),
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS)
  ) u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_valid_i   (in_valid_i),
    .cmd_i        (cmd_i),
    .start_line_i (start_line_i),
    .start_col_i  (start_col_i),
    .end_line_i   (end_line_i),
    .end_col_i    (end_col_i),
    .ctl_o        (ctl_s[0]),
    .sp_o         (sp_s[0]),
    .ep_o         (ep_s[0]),
    .span_o       (span_s[0]),
    .cnt_o        (cnt_s[0]),
    .status_o     (status_s[0])
  );

  assign best_s[0]      = '0;
  assign best_span_s[0] = '0;

  for (genvar k = 0; k < MAX_DEFS; k++) begin : g_cell
    nerl_cell #(
      .MAX_DEFS  (MAX_DEFS),
      .LINE_BITS (LINE_BITS),
      .COL_BITS  (COL_BITS),
      .IDX       (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .ctl_i       (ctl_s[k]),
      .sp_i        (sp_s[k]),
      .ep_i        (ep_s[k]),
      .span_i      (span_s[k]),
      .cnt_i       (cnt_s[k]),
      .best_i      (best_s[k]),
      .best_span_i (best_span_s[k]),
      .status_i    (status_s[k]),
      .ctl_o       (ctl_s[k+1]),
      .sp_o        (sp_s[k+1]),
      .ep_o        (ep_s[k+1]),
      .span_o      (span_s[k+1]),
      .cnt_o       (cnt_s[k+1]),
      .best_o      (best_s[k+1]),
      .best_span_o (best_span_s[k+1]),
      .status_o    (status_s[k+1])
    );
  end

  assign out_valid_o = ctl_s[MAX_DEFS].valid;
  assign status_o    = status_s[MAX_DEFS];
  assign container_o = best_s[MAX_DEFS];

endmodule

FILE: rtl/nerl_checker.sv
// Port-level checks for the narrowest enclosing range lookup, bound to its top level.
// Depends on nerl_pkg for the status codes.
module nerl_checker #(
  parameter int MAX_DEFS = nerl_pkg::MaxDefsDefault,
  localparam int CNT_W   = $clog2(MAX_DEFS + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       status_o,
  input logic [CNT_W-1:0] container_o
);
  import nerl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(container_o))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_container_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && container_o != '0 |-> status_o == ST_OK)
    else $error("container given with error status");

  a_container_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> container_o <= CNT_W'(MAX_DEFS))
    else $error("container index beyond table");

endmodule

bind narrowest_enclosing_range_lookup nerl_checker #(
  .MAX_DEFS (MAX_DEFS)
) u_nerl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .container_o (container_o)
);

FILE: test/nerl_lookup_checker.sv
// Checker for the narrowest enclosing range lookup: watches both channels,
// predicts every result from its own copy of the definition table and compares.
// Depends on nerl_pkg for the command and status codes.
module nerl_lookup_checker #(
  parameter int MAX_DEFS  = 256,
  parameter int LINE_BITS = 20,
  parameter int COL_BITS  = 16,
  localparam int CNT_W    = $clog2(MAX_DEFS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           cmd_i,
  input  logic [LINE_BITS-1:0] start_line_i,
  input  logic [COL_BITS-1:0]  start_col_i,
  input  logic [LINE_BITS-1:0] end_line_i,
  input  logic [COL_BITS-1:0]  end_col_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           status_i,
  input  logic [CNT_W-1:0]     container_i,
  output int                   errors_o,
  output int                   pending_o
);
  import nerl_pkg::*;

  localparam int PosW = LINE_BITS + COL_BITS;

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] container;
  } lookup_res_t;

  pos_t        def_lo    [MAX_DEFS];
  pos_t        def_hi    [MAX_DEFS];
  logic [63:0] def_width [MAX_DEFS];
  int          def_used;

  lookup_res_t expected_results [$];

  function automatic lookup_res_t predict_lookup(
    input logic [1:0]           cmd,
    input logic [LINE_BITS-1:0] sl,
    input logic [COL_BITS-1:0]  sc,
    input logic [LINE_BITS-1:0] el,
    input logic [COL_BITS-1:0]  ec
  );
    lookup_res_t res;
    pos_t        sp;
    pos_t        ep;
    logic [63:0] best_span;
    int          best;
    sp = {sl, sc};
    ep = {el, ec};
    res.status = ST_OK;
    res.container = '0;
    best = 0;
    best_span = '0;
    case (cmd)
      CMD_CLEAR: begin
        def_used = 0;
      end
      CMD_LOAD: begin
        if (ep < sp) begin
          res.status = ST_REVERSED;
        end else if (def_used >= MAX_DEFS) begin
          res.status = ST_FULL;
        end else begin
          def_lo[def_used] = sp;
          def_hi[def_used] = ep;
          def_width[def_used] = (64'(el) - 64'(sl)) * 64'(SpanLineWeight)
                                + 64'(ec) - 64'(sc);
          def_used++;
        end
      end
      CMD_QUERY: begin
        if (ep < sp) begin
          res.status = ST_REVERSED;
        end else begin
          for (int i = 0; i < def_used; i++) begin
            if (def_lo[i] <= sp && def_hi[i] >= ep &&
                (best == 0 || def_width[i] < best_span)) begin
              best = i + 1;
              best_span = def_width[i];
            end
          end
          res.container = CNT_W'(best);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t want;
    if (!rst_ni) begin
      expected_results.delete();
      def_used = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(predict_lookup(cmd_i, start_line_i, start_col_i,
                                                  end_line_i, end_col_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("unexpected result beat: status %0d container %0d",
                     status_i, container_i);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.status !== status_i || want.container !== container_i) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("result mismatch: expected status %0d container %0d, got %0d %0d",
                       want.status, want.container, status_i, container_i);
            end
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: test/narrowest_enclosing_range_lookup_test.sv
// Testbench top for the narrowest enclosing range lookup: clock, reset, stimulus
// and result back-pressure. Depends on nerl_pkg, the block and nerl_lookup_checker.
module narrowest_enclosing_range_lookup_test;
  import nerl_pkg::*;

  localparam int MAX_DEFS    = 256;
  localparam int LINE_BITS   = 20;
  localparam int COL_BITS    = 16;
  localparam int CNT_W       = $clog2(MAX_DEFS + 1);
  localparam int LineMax     = (1 << LINE_BITS) - 1;
  localparam int ColMax      = (1 << COL_BITS) - 1;
  localparam int RandomItems = 800;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic [1:0]           cmd_i        = '0;
  logic [LINE_BITS-1:0] start_line_i = '0;
  logic [COL_BITS-1:0]  start_col_i  = '0;
  logic [LINE_BITS-1:0] end_line_i   = '0;
  logic [COL_BITS-1:0]  end_col_i    = '0;
  logic                 out_stall_i  = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [1:0]           status_o;
  logic [CNT_W-1:0]     container_o;

  int result_errors;
  int results_pending;
  int beats_sent;
  int base_line;
  int base_col;
  bit no_gaps;

  narrowest_enclosing_range_lookup #(
    .MAX_DEFS (MAX_DEFS),
    .LINE_BITS(LINE_BITS),
    .COL_BITS (COL_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .start_line_i(start_line_i),
    .start_col_i (start_col_i),
    .end_line_i  (end_line_i),
    .end_col_i   (end_col_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .container_o (container_o)
  );

  nerl_lookup_checker #(
    .MAX_DEFS (MAX_DEFS),
    .LINE_BITS(LINE_BITS),
    .COL_BITS (COL_BITS)
  ) lookup_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .start_line_i(start_line_i),
    .start_col_i (start_col_i),
    .end_line_i  (end_line_i),
    .end_col_i   (end_col_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .container_i (container_o),
    .errors_o    (result_errors),
    .pending_o   (results_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int pick;
    int len;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 40);
      end else if (pick < 55) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(50, 300);
      end else if (pick < 90) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(10, 60);
      end
      repeat (len) @(negedge clk_i);
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input int sl, input int sc,
                           input int el, input int ec);
    int gap;
    int pick;
    gap = 0;
    pick = $urandom_range(0, 99);
    if (!no_gaps) begin
      if (pick >= 90) begin
        gap = $urandom_range(8, 40);
      end else if (pick >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    start_line_i <= LINE_BITS'(sl);
    start_col_i  <= COL_BITS'(sc);
    end_line_i   <= LINE_BITS'(el);
    end_col_i    <= COL_BITS'(ec);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_noise();
    send_beat(2'($urandom_range(0, 3)), $urandom_range(0, LineMax),
              $urandom_range(0, ColMax), $urandom_range(0, LineMax),
              $urandom_range(0, ColMax));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (results_pending == 0);
  endtask

  task automatic pick_base();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      base_line = 0;
      base_col = 0;
    end else if (pick == 1) begin
      base_line = LineMax - 31;
      base_col = ColMax - 16;
    end else begin
      base_line = $urandom_range(0, LineMax - 31);
      base_col = $urandom_range(0, ColMax - 16);
    end
  endtask

  // ordered range inside the current window; reach bounds the line extent
  task automatic window_range(input int reach, output int sl, output int sc,
                              output int el, output int ec);
    int tmp;
    sl = base_line + $urandom_range(0, 15);
    sc = base_col + $urandom_range(0, 15);
    el = sl + $urandom_range(0, reach);
    ec = base_col + $urandom_range(0, 15);
    if (el == sl && ec < sc) begin
      tmp = sc;
      sc = ec;
      ec = tmp;
    end
  endtask

  task automatic send_window(input logic [1:0] cmd, input int reach);
    int sl, sc, el, ec;
    window_range(reach, sl, sc, el, ec);
    if ($urandom_range(0, 11) == 0) begin
      send_beat(cmd, el, ec, sl, sc);
    end else begin
      send_beat(cmd, sl, sc, el, ec);
    end
  endtask

  task automatic run_window_phase();
    int n_defs;
    int n_queries;
    pick_base();
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7) begin
      send_beat(CMD_CLEAR, $urandom_range(0, LineMax), $urandom_range(0, ColMax),
                $urandom_range(0, LineMax), $urandom_range(0, ColMax));
    end
    n_defs = $urandom_range(1, 10);
    n_queries = $urandom_range(3, 15);
    repeat (n_defs) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_window(CMD_LOAD, 15);
      end
    end
    repeat (n_queries) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1: send_window(CMD_LOAD, 15);
        2: send_window(CMD_QUERY, 15);
        default: send_window(CMD_QUERY, 2);
      endcase
    end
  endtask

  task automatic run_fill_phase();
    int sl, sc, el, ec;
    int pl, pc;
    pick_base();
    no_gaps = 1'b0;
    send_beat(CMD_CLEAR, 0, 0, 0, 0);
    repeat (MAX_DEFS - 1) begin
      window_range(15, sl, sc, el, ec);
      if (sl == el && sc == ec) ec++;
      send_beat(CMD_LOAD, sl, sc, el, ec);
    end
    pl = base_line + $urandom_range(0, 15);
    pc = base_col + $urandom_range(0, 15);
    send_beat(CMD_LOAD, pl, pc, pl, pc);
    window_range(15, sl, sc, el, ec);
    send_beat(CMD_LOAD, sl, sc, el, ec);
    window_range(15, sl, sc, el, ec);
    if (sl == el && sc == ec) ec++;
    send_beat(CMD_LOAD, el, ec, sl, sc);
    send_beat(CMD_QUERY, pl, pc, pl, pc);
    repeat (6) send_window(CMD_QUERY, 2);
    wait_for_results();
  endtask

  initial begin
    int phase;
    beats_sent = 0;
    no_gaps = 1'b0;
    base_line = 0;
    base_col = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(CMD_CLEAR, 0, 0, 0, 0);
    send_beat(CMD_QUERY, 0, 0, 0, 0);
    send_beat(CMD_LOAD, 5, 9, 5, 3);
    send_beat(CMD_LOAD, 9, 0, 3, ColMax);
    send_beat(CMD_LOAD, 0, 0, LineMax, ColMax);
    send_beat(CMD_LOAD, 100, 5, 200, 7);
    send_beat(CMD_LOAD, 100, 5, 200, 7);
    send_beat(CMD_LOAD, LineMax, ColMax, LineMax, ColMax);
    send_beat(CMD_QUERY, 150, 0, 150, ColMax);
    send_beat(CMD_QUERY, LineMax, ColMax, LineMax, ColMax);
    send_beat(CMD_QUERY, 0, 0, LineMax, ColMax);
    send_beat(CMD_QUERY, 7, 7, 7, 6);
    send_beat(CMD_QUERY, 100, 4, 200, 7);
    send_beat(CmdUnused, LineMax, ColMax, LineMax, ColMax);
    send_beat(CMD_LOAD, 50, 0, 60, 0);
    send_beat(CMD_LOAD, 50, 10, 59, 10);
    send_beat(CMD_LOAD, 51, 0, 60, 0);
    send_beat(CMD_LOAD, 10, 60000, 11, 5);
    send_beat(CMD_QUERY, 55, 0, 55, 1);
    send_beat(CMD_QUERY, 10, 60000, 11, 5);
    send_beat(CMD_CLEAR, LineMax, ColMax, LineMax, ColMax);
    send_beat(CMD_QUERY, 55, 0, 55, 1);
    send_beat(CMD_LOAD, 0, 0, 0, 0);
    send_beat(CMD_QUERY, 0, 0, 0, 0);
    wait_for_results();

    phase = 0;
    while (beats_sent < RandomItems + 25) begin
      if (phase == 2 || phase == 12) begin
        run_fill_phase();
      end else begin
        run_window_phase();
        if ($urandom_range(0, 7) == 0) wait_for_results();
      end
      phase++;
    end

    wait_for_results();
    repeat (MAX_DEFS + 16) @(posedge clk_i);
    if (result_errors == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
